>>> hw/rtl/qapm_pkg.sv
// shared types, constants and helpers for the attitude pid mixer
package qapm_pkg;

  localparam int AxisW = 36;
  localparam int SumW  = 37;
  localparam int ThrW  = 13;

  typedef enum logic [2:0] {
    RegPGain         = 3'd0,
    RegIGain         = 3'd1,
    RegDGain         = 3'd2,
    RegIntegralLimit = 3'd3,
    RegRollSetpoint  = 3'd4,
    RegPitchSetpoint = 3'd5,
    RegIntegralEn    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [15:0] d_gain;
    logic [14:0] integral_limit;
    logic        integral_enable;
  } pid_cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [SumW-1:0] x);
    logic signed [15:0] r;
    if (x > SumW'(32767)) begin
      r = 16'sh7fff;
    end else if (x < -SumW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/qapm_if.sv
// valid/ready channels for attitude samples and motor commands
interface qapm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic        [7:0]  base_throttle;

  modport source(output valid, roll_angle, pitch_angle, rate_x, rate_y, base_throttle,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, rate_x, rate_y, base_throttle,
               output ready);
endinterface

interface qapm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_one;
  logic signed [15:0] motor_two;
  logic signed [15:0] motor_three;
  logic signed [15:0] motor_four;

  modport source(output valid, motor_one, motor_two, motor_three, motor_four,
                 input ready);
  modport sink(input valid, motor_one, motor_two, motor_three, motor_four,
               output ready);
endinterface

>>> hw/rtl/qapm_axis.sv
// one pid axis: p, d and clamped integrator with its state register
module qapm_axis #(
  parameter int GainFracBits = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  qapm_pkg::pid_cfg_t               cfg,
  input  logic signed [15:0]               setpoint,
  input  logic signed [15:0]               angle,
  input  logic signed [16:0]               rate,
  input  logic                             update,
  output logic signed [qapm_pkg::AxisW-1:0] axis_out
);
  import qapm_pkg::*;

  // truncate toward zero after dropping the fraction bits
  function automatic logic signed [34:0] shr_trunc(input logic signed [34:0] x);
    logic signed [34:0] q;
    q = x >>> GainFracBits;
    if (x[34] && (x[GainFracBits-1:0] != '0)) begin
      q = q + 35'sd1;
    end
    return q;
  endfunction

  logic signed [15:0] integ;
  logic signed [16:0] err;
  logic signed [33:0] pprod;
  logic signed [33:0] iprod;
  logic signed [33:0] dprod;
  logic signed [34:0] p_term;
  logic signed [34:0] d_term;
  logic signed [34:0] acc;
  logic signed [34:0] ni;
  logic signed [34:0] lim_pos;
  logic signed [15:0] integ_next;
  logic signed [AxisW-1:0] i_term;

  always_comb begin
    err     = 17'(setpoint) - 17'(angle);
    pprod   = $signed({1'b0, cfg.p_gain}) * err;
    iprod   = $signed({1'b0, cfg.i_gain}) * err;
    dprod   = $signed({1'b0, cfg.d_gain}) * rate;
    p_term  = shr_trunc(35'(pprod));
    d_term  = shr_trunc(35'(dprod));
    acc     = (35'(integ) <<< GainFracBits) + 35'(iprod);
    ni      = shr_trunc(acc);
    lim_pos = $signed({20'b0, cfg.integral_limit});
    if (ni > lim_pos) begin
      integ_next = lim_pos[15:0];
    end else if (ni < -lim_pos) begin
      integ_next = 16'(-lim_pos);
    end else begin
      integ_next = ni[15:0];
    end
    i_term   = cfg.integral_enable ? AxisW'(integ_next) : '0;
    axis_out = AxisW'(p_term) + i_term - AxisW'(d_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (update) begin
      integ <= integ_next;
    end
  end

endmodule

>>> hw/rtl/quad_attitude_pid_mixer_top.sv
// attitude pid for roll and pitch with plus-layout motor mixer
// an accepted input passes through the input register, then the result register, to the sink
// throughput: one item per cycle; the integrators update in the same cycle they are read
// output register stalls only when the sink holds ready low
// reset: synchronous, clears pipeline valids, both integrators, and loads default gains
module quad_attitude_pid_mixer_top #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  qapm_in_if.sink           in_ch,
  qapm_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import qapm_pkg::*;

  pid_cfg_t           cfg;
  logic signed [15:0] roll_setpoint;
  logic signed [15:0] pitch_setpoint;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain          <= 16'd2662;
      cfg.i_gain          <= 16'd1024;
      cfg.d_gain          <= 16'd164;
      cfg.integral_limit  <= 15'd100;
      cfg.integral_enable <= 1'b0;
      roll_setpoint       <= -16'sd28;
      pitch_setpoint      <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        RegPGain:         cfg.p_gain          <= cfg_data;
        RegIGain:         cfg.i_gain          <= cfg_data;
        RegDGain:         cfg.d_gain          <= cfg_data;
        RegIntegralLimit: cfg.integral_limit  <= cfg_data[14:0];
        RegRollSetpoint:  roll_setpoint       <= cfg_data;
        RegPitchSetpoint: pitch_setpoint      <= cfg_data;
        RegIntegralEn:    cfg.integral_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic               s1_valid;
  logic signed [15:0] s1_roll;
  logic signed [15:0] s1_pitch;
  logic signed [15:0] s1_rate_x;
  logic signed [15:0] s1_rate_y;
  logic        [7:0]  s1_throttle;
  logic               out_valid;
  logic               advance;
  logic               s1_move;
  logic               in_take;

  assign advance      = !out_valid || out_ch.ready;
  assign s1_move      = s1_valid && advance;
  assign in_ch.ready  = !s1_valid || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_roll     <= in_ch.roll_angle;
      s1_pitch    <= in_ch.pitch_angle;
      s1_rate_x   <= in_ch.rate_x;
      s1_rate_y   <= in_ch.rate_y;
      s1_throttle <= in_ch.base_throttle;
    end
  end

  logic                    thr_on;
  logic                    upd;
  logic signed [ThrW-1:0]  thr;
  logic signed [16:0]      roll_rate;
  logic signed [16:0]      pitch_rate;
  logic signed [AxisW-1:0] roll_out;
  logic signed [AxisW-1:0] pitch_out;

  assign thr_on     = (s1_throttle != 8'd0);
  assign upd        = s1_move && thr_on;
  assign thr        = ThrW'(($signed({5'b0, s1_throttle}) - 13'sd1) * 13'sd10);
  assign roll_rate  = 17'(s1_rate_y);
  // pitch damps on the negated x rate
  assign pitch_rate = -17'(s1_rate_x);

  qapm_axis #(.GainFracBits(GAIN_FRAC_BITS)) u_roll (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .setpoint (roll_setpoint),
    .angle    (s1_roll),
    .rate     (roll_rate),
    .update   (upd),
    .axis_out (roll_out)
  );

  qapm_axis #(.GainFracBits(GAIN_FRAC_BITS)) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .setpoint (pitch_setpoint),
    .angle    (s1_pitch),
    .rate     (pitch_rate),
    .update   (upd),
    .axis_out (pitch_out)
  );

  logic signed [15:0] m1_next;
  logic signed [15:0] m2_next;
  logic signed [15:0] m3_next;
  logic signed [15:0] m4_next;

  always_comb begin
    if (thr_on) begin
      m1_next = sat16(SumW'(thr) + SumW'(roll_out));
      m2_next = sat16(SumW'(thr) + SumW'(pitch_out));
      m3_next = sat16(SumW'(thr) - SumW'(roll_out));
      m4_next = sat16(SumW'(thr) - SumW'(pitch_out));
    end else begin
      m1_next = '0;
      m2_next = '0;
      m3_next = '0;
      m4_next = '0;
    end
  end

  // result register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_ch.motor_one   <= m1_next;
      out_ch.motor_two   <= m2_next;
      out_ch.motor_three <= m3_next;
      out_ch.motor_four  <= m4_next;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  a_out_from_stage1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared with no item in the input stage");

  a_zero_throttle: assert property (@(posedge clk) disable iff (rst)
    (s1_move && !thr_on) |=> (out_ch.motor_one == 16'sd0 && out_ch.motor_two == 16'sd0 &&
      out_ch.motor_three == 16'sd0 && out_ch.motor_four == 16'sd0))
    else $error("zero throttle item gave nonzero motor command");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_valid && !out_ch.ready))
    else $error("input stalled while pipeline had room");

  a_no_update_when_idle: assert property (@(posedge clk) disable iff (rst)
    upd |-> (s1_valid && advance))
    else $error("integrator update without an item moving");
`endif

endmodule
